FILE: sv/tlsr_pkg.sv
// Thick line span rasteriser: shared types, codes and default constants.
// Used by every other file of the block; depends on nothing.
package tlsr_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int MAX_THICKNESS_DEF = 32;
  localparam int MAX_DIM_DEF       = 4096;

  localparam int DIM_BITS     = 13;
  localparam int SPAN_BITS    = 12;
  localparam int THK_IN_BITS  = 6;
  localparam int CHAN_BITS    = 8;
  localparam int COLOUR_BITS  = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 13'd4096;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_HAS_ALPHA    = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    PH_LINE    = 2'd0,
    PH_DOT_ROW = 2'd1,
    PH_DOT_COL = 2'd2
  } phase_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic                has_alpha;
  } cfg_t;

endpackage

FILE: sv/tlsr_in_if.sv
// Input channel of the thick line span rasteriser: valid/ready plus line fields.
// Depends on tlsr_pkg for default widths.
interface tlsr_in_if #(
  parameter int COORD_BITS = tlsr_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic signed [COORD_BITS-1:0]      x_start;
  logic signed [COORD_BITS-1:0]      y_start;
  logic signed [COORD_BITS-1:0]      x_end;
  logic signed [COORD_BITS-1:0]      y_end;
  logic [tlsr_pkg::THK_IN_BITS-1:0]  thickness;
  logic [tlsr_pkg::CHAN_BITS-1:0]    red;
  logic [tlsr_pkg::CHAN_BITS-1:0]    green;
  logic [tlsr_pkg::CHAN_BITS-1:0]    blue;
  logic [tlsr_pkg::CHAN_BITS-1:0]    alpha;

  modport source (
    output valid, kind, x_start, y_start, x_end, y_end, thickness, red, green, blue, alpha,
    input  ready
  );
  modport sink (
    input  valid, kind, x_start, y_start, x_end, y_end, thickness, red, green, blue, alpha,
    output ready
  );
endinterface

FILE: sv/tlsr_out_if.sv
// Result channel of the thick line span rasteriser: valid/ready plus span fields.
// Depends on tlsr_pkg for field widths.
interface tlsr_out_if;
  logic                            valid;
  logic                            ready;
  logic [tlsr_pkg::SPAN_BITS-1:0]  span_x_first;
  logic [tlsr_pkg::SPAN_BITS-1:0]  span_y_first;
  logic [tlsr_pkg::SPAN_BITS-1:0]  span_x_last;
  logic [tlsr_pkg::SPAN_BITS-1:0]  span_y_last;
  logic                            span_empty;
  logic                            line_done;
  logic [tlsr_pkg::CHAN_BITS-1:0]  out_red;
  logic [tlsr_pkg::CHAN_BITS-1:0]  out_green;
  logic [tlsr_pkg::CHAN_BITS-1:0]  out_blue;
  logic [tlsr_pkg::CHAN_BITS-1:0]  out_alpha;

  modport source (
    output valid, span_x_first, span_y_first, span_x_last, span_y_last, span_empty,
           line_done, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, span_x_first, span_y_first, span_x_last, span_y_last, span_empty,
           line_done, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

FILE: sv/tlsr_front.sv
// Front end: accepts items, forms endpoint deltas and their magnitudes over two stages.
// Depends on tlsr_pkg and tlsr_in_if.
module tlsr_front #(
  parameter int COORD_BITS    = tlsr_pkg::COORD_BITS_DEF,
  parameter int MAX_THICKNESS = tlsr_pkg::MAX_THICKNESS_DEF,
  parameter int THK_BITS      = $clog2(MAX_THICKNESS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tlsr_in_if.sink                       in_if,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic                          q_kind,
  output logic signed [COORD_BITS-1:0]  q_x1,
  output logic signed [COORD_BITS-1:0]  q_y1,
  output logic signed [COORD_BITS-1:0]  q_x2,
  output logic signed [COORD_BITS-1:0]  q_y2,
  output logic [COORD_BITS-1:0]         q_adx,
  output logic [COORD_BITS-1:0]         q_ady,
  output logic                          q_nx,
  output logic                          q_ny,
  output logic [THK_BITS-1:0]           q_thick,
  output logic [tlsr_pkg::COLOUR_BITS-1:0] q_colour
);

  localparam int THK_CMP_BITS = 9;

  logic                          s1_v_r, s2_v_r;
  logic                          s1_rdy, s2_rdy;
  logic                          s1_kind_r, s2_kind_r;
  logic signed [COORD_BITS-1:0]  s1_x1_r, s1_y1_r, s1_x2_r, s1_y2_r;
  logic signed [COORD_BITS-1:0]  s2_x1_r, s2_y1_r, s2_x2_r, s2_y2_r;
  logic signed [COORD_BITS:0]    s1_dx_r, s1_dy_r;
  logic signed [COORD_BITS:0]    dx_in, dy_in, dx_neg, dy_neg;
  logic [COORD_BITS-1:0]         s2_adx_r, s2_ady_r;
  logic                          s2_nx_r, s2_ny_r;
  logic [THK_BITS-1:0]           thk_sat, s1_thk_r, s2_thk_r;
  logic [tlsr_pkg::COLOUR_BITS-1:0] s1_col_r, s2_col_r;

  assign s2_rdy      = !s2_v_r || q_ready;
  assign s1_rdy      = !s1_v_r || s2_rdy;
  assign in_if.ready = s1_rdy;

  always_comb begin
    dx_in = {in_if.x_end[COORD_BITS-1], in_if.x_end} -
            {in_if.x_start[COORD_BITS-1], in_if.x_start};
    dy_in = {in_if.y_end[COORD_BITS-1], in_if.y_end} -
            {in_if.y_start[COORD_BITS-1], in_if.y_start};
    if (THK_CMP_BITS'(in_if.thickness) > THK_CMP_BITS'(MAX_THICKNESS)) begin
      thk_sat = THK_BITS'(MAX_THICKNESS);
    end else begin
      thk_sat = THK_BITS'(in_if.thickness);
    end
    dx_neg = -s1_dx_r;
    dy_neg = -s1_dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_if.valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && s1_rdy) begin
      s1_kind_r <= in_if.kind;
      s1_x1_r   <= in_if.x_start;
      s1_y1_r   <= in_if.y_start;
      s1_x2_r   <= in_if.x_end;
      s1_y2_r   <= in_if.y_end;
      s1_dx_r   <= dx_in;
      s1_dy_r   <= dy_in;
      s1_thk_r  <= thk_sat;
      s1_col_r  <= {in_if.red, in_if.green, in_if.blue, in_if.alpha};
    end
    if (s1_v_r && s2_rdy) begin
      s2_kind_r <= s1_kind_r;
      s2_x1_r   <= s1_x1_r;
      s2_y1_r   <= s1_y1_r;
      s2_x2_r   <= s1_x2_r;
      s2_y2_r   <= s1_y2_r;
      s2_adx_r  <= s1_dx_r[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : s1_dx_r[COORD_BITS-1:0];
      s2_ady_r  <= s1_dy_r[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : s1_dy_r[COORD_BITS-1:0];
      s2_nx_r   <= s1_dx_r[COORD_BITS];
      s2_ny_r   <= s1_dy_r[COORD_BITS];
      s2_thk_r  <= s1_thk_r;
      s2_col_r  <= s1_col_r;
    end
  end

  assign q_valid  = s2_v_r;
  assign q_kind   = s2_kind_r;
  assign q_x1     = s2_x1_r;
  assign q_y1     = s2_y1_r;
  assign q_x2     = s2_x2_r;
  assign q_y2     = s2_y2_r;
  assign q_adx    = s2_adx_r;
  assign q_ady    = s2_ady_r;
  assign q_nx     = s2_nx_r;
  assign q_ny     = s2_ny_r;
  assign q_thick  = s2_thk_r;
  assign q_colour = s2_col_r;

endmodule

FILE: sv/tlsr_fifo.sv
// Short item queue between front and back end; power-of-two depth, first word fall-through.
// Depends on tlsr_pkg for the default depth.
module tlsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tlsr_pkg::QUEUE_DEPTH,
  parameter int CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  logic [WIDTH-1:0]    wr_data,
  output logic                rd_valid,
  input  logic                rd_pop,
  output logic [WIDTH-1:0]    rd_data,
  output logic [CNT_BITS-1:0] count
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                push, pop;

  assign wr_ready = (cnt_r != CNT_BITS'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_data  = mem[rd_ptr_r];
  assign count    = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_BITS'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      if (push && !pop) cnt_r <= cnt_r + CNT_BITS'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

endmodule

FILE: sv/tlsr_back.sv
// Back end: holds the current line, steps it one span per tick and clips to the image.
// Depends on tlsr_pkg and tlsr_out_if.
module tlsr_back #(
  parameter int COORD_BITS    = tlsr_pkg::COORD_BITS_DEF,
  parameter int MAX_THICKNESS = tlsr_pkg::MAX_THICKNESS_DEF,
  parameter int THK_BITS      = $clog2(MAX_THICKNESS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tlsr_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic                          q_kind,
  input  logic signed [COORD_BITS-1:0]  q_x1,
  input  logic signed [COORD_BITS-1:0]  q_y1,
  input  logic signed [COORD_BITS-1:0]  q_x2,
  input  logic signed [COORD_BITS-1:0]  q_y2,
  input  logic [COORD_BITS-1:0]         q_adx,
  input  logic [COORD_BITS-1:0]         q_ady,
  input  logic                          q_nx,
  input  logic                          q_ny,
  input  logic [THK_BITS-1:0]           q_thick,
  input  logic [tlsr_pkg::COLOUR_BITS-1:0] q_colour,
  tlsr_out_if.source                    out_if
);

  localparam int CW = (COORD_BITS + 2 > 15) ? COORD_BITS + 2 : 15;
  localparam int SB = tlsr_pkg::SPAN_BITS;
  localparam int DB = tlsr_pkg::DIM_BITS;
  localparam int CB = tlsr_pkg::CHAN_BITS;

  // line state
  logic                          active_r, active_nxt;
  tlsr_pkg::phase_t              phase_r, phase_nxt;
  logic                          major_y_r, major_y_nxt;
  logic                          mneg_r, mneg_nxt;
  logic signed [COORD_BITS-1:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0]         rem_r, rem_nxt, err_r, err_nxt;
  logic [COORD_BITS-1:0]         diff_r, diff_nxt, mdm_r, mdm_nxt;
  logic [THK_BITS-1:0]           thick_r, thick_nxt;
  logic [tlsr_pkg::COLOUR_BITS-1:0] col_r, col_nxt;

  // load decode
  logic                          ld_deg, ld_my, ld_swap, ld_mneg;
  logic [COORD_BITS-1:0]         ld_md, ld_mdm;
  logic signed [COORD_BITS-1:0]  minor_step;

  // span
  logic                          out_free, tick_go;
  logic                          along_x, sp_empty, sp_done;
  logic signed [CW-1:0]          f_w, c_w, lo_w, hi_w, limf_w, limr_w, limr_m1, lo_c, hi_c;
  logic [THK_BITS-1:0]           t_m1;
  logic [SB-1:0]                 sp_xf, sp_yf, sp_xl, sp_yl;
  logic [CB-1:0]                 sp_r, sp_g, sp_b, sp_a;

  logic                          out_valid_r;
  logic [SB-1:0]                 o_xf_r, o_yf_r, o_xl_r, o_yl_r;
  logic                          o_empty_r, o_done_r;
  logic [CB-1:0]                 o_r_r, o_g_r, o_b_r, o_a_r;

  assign out_free = !out_valid_r || out_if.ready;
  assign q_pop    = q_valid && ((q_kind == tlsr_pkg::KIND_LOAD) || out_free);
  assign tick_go  = q_pop && (q_kind == tlsr_pkg::KIND_TICK);

  always_comb begin
    ld_deg     = (q_adx == '0) && (q_ady == '0);
    ld_my      = q_ady > q_adx;
    ld_swap    = ld_my ? q_ny : q_nx;
    ld_md      = ld_my ? q_ady : q_adx;
    ld_mdm     = ld_my ? q_adx : q_ady;
    ld_mneg    = (ld_my ? q_nx : q_ny) ^ ld_swap;
    minor_step = mneg_r ? -COORD_BITS'(1) : COORD_BITS'(1);
  end

  // next state
  always_comb begin
    active_nxt  = active_r;
    phase_nxt   = phase_r;
    major_y_nxt = major_y_r;
    mneg_nxt    = mneg_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    rem_nxt     = rem_r;
    err_nxt     = err_r;
    diff_nxt    = diff_r;
    mdm_nxt     = mdm_r;
    thick_nxt   = thick_r;
    col_nxt     = col_r;
    if (q_pop && (q_kind == tlsr_pkg::KIND_LOAD)) begin
      active_nxt  = 1'b1;
      phase_nxt   = ld_deg ? tlsr_pkg::PH_DOT_ROW : tlsr_pkg::PH_LINE;
      major_y_nxt = ld_my;
      mneg_nxt    = ld_mneg;
      cur_x_nxt   = ld_swap ? q_x2 : q_x1;
      cur_y_nxt   = ld_swap ? q_y2 : q_y1;
      rem_nxt     = ld_md;
      err_nxt     = '0;
      diff_nxt    = ld_md - ld_mdm;
      mdm_nxt     = ld_mdm;
      thick_nxt   = q_thick;
      col_nxt     = q_colour;
    end else if (tick_go && active_r) begin
      unique case (phase_r)
        tlsr_pkg::PH_DOT_ROW: phase_nxt = tlsr_pkg::PH_DOT_COL;
        tlsr_pkg::PH_DOT_COL: begin
          phase_nxt  = tlsr_pkg::PH_LINE;
          active_nxt = 1'b0;
        end
        tlsr_pkg::PH_LINE: begin
          if (rem_r == '0) begin
            active_nxt = 1'b0;
          end else begin
            rem_nxt = rem_r - COORD_BITS'(1);
            if (major_y_r) cur_y_nxt = cur_y_r + COORD_BITS'(1);
            else           cur_x_nxt = cur_x_r + COORD_BITS'(1);
            if (err_r >= diff_r) begin
              err_nxt = err_r - diff_r;
              if (major_y_r) cur_x_nxt = cur_x_r + minor_step;
              else           cur_y_nxt = cur_y_r + minor_step;
            end else begin
              err_nxt = err_r + mdm_r;
            end
          end
        end
        default: phase_nxt = tlsr_pkg::PH_LINE;
      endcase
    end
  end

  // span for the current step
  always_comb begin
    along_x = (phase_r == tlsr_pkg::PH_DOT_ROW) ||
              ((phase_r == tlsr_pkg::PH_LINE) && major_y_r);
    f_w     = along_x ? {{(CW-COORD_BITS){cur_y_r[COORD_BITS-1]}}, cur_y_r}
                      : {{(CW-COORD_BITS){cur_x_r[COORD_BITS-1]}}, cur_x_r};
    c_w     = along_x ? {{(CW-COORD_BITS){cur_x_r[COORD_BITS-1]}}, cur_x_r}
                      : {{(CW-COORD_BITS){cur_y_r[COORD_BITS-1]}}, cur_y_r};
    limf_w  = along_x ? $signed({{(CW-DB){1'b0}}, cfg.height})
                      : $signed({{(CW-DB){1'b0}}, cfg.width});
    limr_w  = along_x ? $signed({{(CW-DB){1'b0}}, cfg.width})
                      : $signed({{(CW-DB){1'b0}}, cfg.height});
    limr_m1 = limr_w - $signed(CW'(1));
    t_m1    = thick_r - THK_BITS'(1);
    lo_w    = c_w - $signed({{(CW-THK_BITS){1'b0}}, t_m1 >> 1});
    hi_w    = c_w + $signed({{(CW-THK_BITS){1'b0}}, thick_r >> 1});
    sp_empty = !active_r || (thick_r == '0) || f_w[CW-1] || (f_w >= limf_w) ||
               hi_w[CW-1] || (lo_w >= limr_w);
    lo_c    = lo_w[CW-1] ? '0 : lo_w;
    hi_c    = (hi_w > limr_m1) ? limr_m1 : hi_w;
    sp_done = !active_r || (phase_r == tlsr_pkg::PH_DOT_COL) ||
              ((phase_r == tlsr_pkg::PH_LINE) && (rem_r == '0));
    sp_xf = '0;
    sp_yf = '0;
    sp_xl = '0;
    sp_yl = '0;
    if (!sp_empty) begin
      if (along_x) begin
        sp_xf = lo_c[SB-1:0];
        sp_xl = hi_c[SB-1:0];
        sp_yf = f_w[SB-1:0];
        sp_yl = f_w[SB-1:0];
      end else begin
        sp_yf = lo_c[SB-1:0];
        sp_yl = hi_c[SB-1:0];
        sp_xf = f_w[SB-1:0];
        sp_xl = f_w[SB-1:0];
      end
    end
    sp_r = active_r ? col_r[4*CB-1:3*CB] : '0;
    sp_g = active_r ? col_r[3*CB-1:2*CB] : '0;
    sp_b = active_r ? col_r[2*CB-1:CB] : '0;
    sp_a = (active_r && cfg.has_alpha) ? col_r[CB-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      phase_r     <= tlsr_pkg::PH_LINE;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      if (tick_go)           out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    major_y_r <= major_y_nxt;
    mneg_r    <= mneg_nxt;
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    rem_r     <= rem_nxt;
    err_r     <= err_nxt;
    diff_r    <= diff_nxt;
    mdm_r     <= mdm_nxt;
    thick_r   <= thick_nxt;
    col_r     <= col_nxt;
    if (tick_go) begin
      o_xf_r    <= sp_xf;
      o_yf_r    <= sp_yf;
      o_xl_r    <= sp_xl;
      o_yl_r    <= sp_yl;
      o_empty_r <= sp_empty;
      o_done_r  <= sp_done;
      o_r_r     <= sp_r;
      o_g_r     <= sp_g;
      o_b_r     <= sp_b;
      o_a_r     <= sp_a;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.span_x_first = o_xf_r;
  assign out_if.span_y_first = o_yf_r;
  assign out_if.span_x_last  = o_xl_r;
  assign out_if.span_y_last  = o_yl_r;
  assign out_if.span_empty   = o_empty_r;
  assign out_if.line_done    = o_done_r;
  assign out_if.out_red      = o_r_r;
  assign out_if.out_green    = o_g_r;
  assign out_if.out_blue     = o_b_r;
  assign out_if.out_alpha    = o_a_r;

endmodule

FILE: sv/thick_line_span_rasterizer_unit.sv
// Thick line span rasteriser, top level. A tick goes through the two front stages, the
// queue and the result register; loads give no result. Throughput: one item per cycle,
// set by the back end's error/step update; ticks wait while a result is held untaken.
// Reset: synchronous, active low; clears the pipeline, queue and line, sets image size
// to 4096 x 4096 (capped at MAX_DIM) with alpha present. Depends on all other files.
module thick_line_span_rasterizer_unit #(
  parameter int COORD_BITS    = tlsr_pkg::COORD_BITS_DEF,
  parameter int MAX_THICKNESS = tlsr_pkg::MAX_THICKNESS_DEF,
  parameter int MAX_DIM       = tlsr_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tlsr_in_if.sink                            in_if,
  tlsr_out_if.source                         out_if,
  input  logic                               cfg_we,
  input  logic [tlsr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tlsr_pkg::DIM_BITS-1:0]      cfg_data
);

  localparam int THK_BITS = $clog2(MAX_THICKNESS + 1);
  localparam int DB       = tlsr_pkg::DIM_BITS;
  localparam int QW       = 1 + 6 * COORD_BITS + 2 + THK_BITS + tlsr_pkg::COLOUR_BITS;
  localparam int CNT_BITS = $clog2(tlsr_pkg::QUEUE_DEPTH + 1);
  localparam logic [DB-1:0] DIM_CAP = (MAX_DIM > 8191) ? 13'h1FFF : DB'(MAX_DIM);

  tlsr_pkg::cfg_t                cfg_r;
  logic [DB-1:0]                 dim_wr;

  logic                          f_valid, f_ready;
  logic                          f_kind, f_nx, f_ny;
  logic signed [COORD_BITS-1:0]  f_x1, f_y1, f_x2, f_y2;
  logic [COORD_BITS-1:0]         f_adx, f_ady;
  logic [THK_BITS-1:0]           f_thick;
  logic [tlsr_pkg::COLOUR_BITS-1:0] f_colour;

  logic                          q_valid, q_pop;
  logic [QW-1:0]                 q_wdata, q_rdata;
  logic [CNT_BITS-1:0]           q_cnt;
  logic                          b_kind, b_nx, b_ny;
  logic signed [COORD_BITS-1:0]  b_x1, b_y1, b_x2, b_y2;
  logic [COORD_BITS-1:0]         b_adx, b_ady;
  logic [THK_BITS-1:0]           b_thick;
  logic [tlsr_pkg::COLOUR_BITS-1:0] b_colour;

  assign dim_wr = (cfg_data > DIM_CAP) ? DIM_CAP : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width     <= (tlsr_pkg::DIM_RESET > DIM_CAP) ? DIM_CAP : tlsr_pkg::DIM_RESET;
      cfg_r.height    <= (tlsr_pkg::DIM_RESET > DIM_CAP) ? DIM_CAP : tlsr_pkg::DIM_RESET;
      cfg_r.has_alpha <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlsr_pkg::CFG_IMAGE_WIDTH:  cfg_r.width     <= dim_wr;
        tlsr_pkg::CFG_IMAGE_HEIGHT: cfg_r.height    <= dim_wr;
        tlsr_pkg::CFG_HAS_ALPHA:    cfg_r.has_alpha <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tlsr_front #(
    .COORD_BITS    (COORD_BITS),
    .MAX_THICKNESS (MAX_THICKNESS),
    .THK_BITS      (THK_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_kind   (f_kind),
    .q_x1     (f_x1),
    .q_y1     (f_y1),
    .q_x2     (f_x2),
    .q_y2     (f_y2),
    .q_adx    (f_adx),
    .q_ady    (f_ady),
    .q_nx     (f_nx),
    .q_ny     (f_ny),
    .q_thick  (f_thick),
    .q_colour (f_colour)
  );

  assign q_wdata = {f_kind, f_x1, f_y1, f_x2, f_y2, f_adx, f_ady, f_nx, f_ny, f_thick, f_colour};
  assign {b_kind, b_x1, b_y1, b_x2, b_y2, b_adx, b_ady, b_nx, b_ny, b_thick, b_colour} = q_rdata;

  tlsr_fifo #(
    .WIDTH    (QW),
    .DEPTH    (tlsr_pkg::QUEUE_DEPTH),
    .CNT_BITS (CNT_BITS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (q_wdata),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_rdata),
    .count    (q_cnt)
  );

  tlsr_back #(
    .COORD_BITS    (COORD_BITS),
    .MAX_THICKNESS (MAX_THICKNESS),
    .THK_BITS      (THK_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_kind   (b_kind),
    .q_x1     (b_x1),
    .q_y1     (b_y1),
    .q_x2     (b_x2),
    .q_y2     (b_y2),
    .q_adx    (b_adx),
    .q_ady    (b_ady),
    .q_nx     (b_nx),
    .q_ny     (b_ny),
    .q_thick  (b_thick),
    .q_colour (b_colour),
    .out_if   (out_if)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= CNT_BITS'(tlsr_pkg::QUEUE_DEPTH))
    else $error("item queue overfilled");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_if.valid && q_pop && (b_kind == tlsr_pkg::KIND_LOAD)) |=> !out_if.valid)
    else $error("load item produced a result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.span_empty) |->
      (out_if.span_x_first == '0) && (out_if.span_y_first == '0) &&
      (out_if.span_x_last == '0) && (out_if.span_y_last == '0))
    else $error("empty span with non-zero corners");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.span_empty) |->
      (out_if.span_x_first <= out_if.span_x_last) &&
      (out_if.span_y_first <= out_if.span_y_last))
    else $error("clipped span corners out of order");
`endif

endmodule
